// ===== src/gopd_pkg.sv =====
`timescale 1ns / 1ps
// package for the glyph outline point decoder
// parse phase codes, result status codes and parameter defaults; no dependencies

package gopd_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int MAX_CONTOURS_DEF = 32;

    localparam int HEAD_BYTES = 10;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HEAD  = 3'd1;
    localparam logic [2:0] PH_ENDS  = 3'd2;
    localparam logic [2:0] PH_ILEN  = 3'd3;
    localparam logic [2:0] PH_INSTR = 3'd4;
    localparam logic [2:0] PH_FLAGS = 3'd5;
    localparam logic [2:0] PH_XS    = 3'd6;
    localparam logic [2:0] PH_YS    = 3'd7;

    localparam logic [1:0] ST_POINT    = 2'd0;
    localparam logic [1:0] ST_NO_CONT  = 2'd1;
    localparam logic [1:0] ST_COMPOUND = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

endpackage

// ===== src/gopd_store.sv =====
`timescale 1ns / 1ps
// point and contour stores: flag, x coordinate and contour end memories
// registered synchronous read with write-to-read forwarding; uses no package

module gopd_store #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CONTOURS = 32,
    parameter int PW           = 7,
    parameter int CW           = 6
) (
    input  logic          clk,
    input  logic [PW-1:0] pt_rd,
    input  logic [CW-1:0] ct_rd,
    input  logic          flag_we,
    input  logic [PW-1:0] flag_wa,
    input  logic [5:0]    flag_wd,
    input  logic          x_we,
    input  logic [PW-1:0] x_wa,
    input  logic [15:0]   x_wd,
    input  logic          ce_we,
    input  logic [CW-1:0] ce_wa,
    input  logic [15:0]   ce_wd,
    output logic [5:0]    flag_q,
    output logic [15:0]   x_q,
    output logic [15:0]   ce_q
);

    localparam int PAW = $clog2(MAX_POINTS);
    localparam int CAW = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;

    logic [5:0]  flag_mem [MAX_POINTS];
    logic [15:0] x_mem    [MAX_POINTS];
    logic [15:0] ce_mem   [MAX_CONTOURS];

    logic [PAW-1:0] pt_ra;
    logic [PAW-1:0] flag_a;
    logic [PAW-1:0] x_a;
    logic [CAW-1:0] ct_ra;
    logic [CAW-1:0] ce_a;

    assign pt_ra  = (pt_rd < PW'(MAX_POINTS)) ? pt_rd[PAW-1:0] : '0;
    assign flag_a = (flag_wa < PW'(MAX_POINTS)) ? flag_wa[PAW-1:0] : '0;
    assign x_a    = (x_wa < PW'(MAX_POINTS)) ? x_wa[PAW-1:0] : '0;
    assign ct_ra  = (ct_rd < CW'(MAX_CONTOURS)) ? ct_rd[CAW-1:0] : '0;
    assign ce_a   = (ce_wa < CW'(MAX_CONTOURS)) ? ce_wa[CAW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_a] <= flag_wd;
        end
        if (x_we)
        begin
            x_mem[x_a] <= x_wd;
        end
        if (ce_we)
        begin
            ce_mem[ce_a] <= ce_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_q <= (flag_we && flag_wa == pt_rd) ? flag_wd : flag_mem[pt_ra];
        x_q    <= (x_we && x_wa == pt_rd) ? x_wd : x_mem[pt_ra];
        ce_q   <= (ce_we && ce_wa == ct_rd) ? ce_wd : ce_mem[ct_ra];
    end

endmodule

// ===== src/glyph_outline_point_decoder_unit.sv =====
`timescale 1ns / 1ps
// simple glyph record parser: header, contour ends, flags, x and y deltas to points
// depends on gopd_pkg and gopd_store
//
//  channel | signals                                               | direction
//  in      | in_valid, in_stall, data_byte, start_req              | byte beat in
//  out     | out_valid, out_stall, point_x, point_y, on_curve,     | result beat out
//          | contour_end, status, last                             |
//
// a header, end index, length, instruction or flag byte is taken in S_IN
// a byte that completes an x delta then passes through S_XSET, one that completes a y delta through S_WALK and S_YSET
// a repeat count writes its repeated flags in S_REP, a byte-less x is written in S_XSET,
// a byte-less y goes through S_YSET and S_WALK, and each contour end passed over is stepped in S_WALK before its point
// reset clears all control state; the stores need no clearing
// in_stall is high while the sequencer loops or while a result beat is held

module glyph_outline_point_decoder_unit #(
    parameter int MAX_POINTS   = gopd_pkg::MAX_POINTS_DEF,
    parameter int MAX_CONTOURS = gopd_pkg::MAX_CONTOURS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               start_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic               on_curve,
    output logic               contour_end,
    output logic [1:0]         status,
    output logic               last
);

    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(MAX_CONTOURS + 1);

    localparam logic [2:0] S_IN   = 3'd0;
    localparam logic [2:0] S_REP  = 3'd1;
    localparam logic [2:0] S_XSET = 3'd2;
    localparam logic [2:0] S_YSET = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;

    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    seq_reg, seq_next;
    logic [3:0]    fbc_reg, fbc_next;
    logic [7:0]    hb_reg, hb_next;
    logic [CW-1:0] ctot_reg, ctot_next;
    logic [CW-1:0] cp_reg, cp_next;
    logic [PW-1:0] ptot_reg, ptot_next;
    logic [PW-1:0] pp_reg, pp_next;
    logic [15:0]   ilen_reg, ilen_next;
    logic [7:0]    rep_reg, rep_next;
    logic [15:0]   xr_reg, xr_next;
    logic [15:0]   yr_reg, yr_next;
    logic          ce_acc_reg, ce_acc_next;

    logic          ovalid_reg, ovalid_next;
    logic [15:0]   px_reg, px_next;
    logic [15:0]   py_reg, py_next;
    logic          on_reg, on_next;
    logic          ce_reg, ce_next;
    logic [1:0]    st_reg, st_next;
    logic          last_reg, last_next;

    logic          flag_we;
    logic [PW-1:0] flag_wa;
    logic [5:0]    flag_wd;
    logic          x_we;
    logic [15:0]   x_wd;
    logic          ce_we;
    logic [15:0]   ce_wd;
    logic [5:0]    flag_q;
    logic [15:0]   x_q;
    logic [15:0]   ce_q;

    logic          accept;
    logic          out_free;

    assign out_free  = !ovalid_reg || !out_stall;
    assign in_stall  = (seq_reg != S_IN) || !out_free;
    assign accept    = in_valid && !in_stall;

    assign out_valid   = ovalid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign on_curve    = on_reg;
    assign contour_end = ce_reg;
    assign status      = st_reg;
    assign last        = last_reg;

    gopd_store #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CONTOURS (MAX_CONTOURS),
        .PW           (PW),
        .CW           (CW)
    ) u_store (
        .clk     (clk),
        .pt_rd   (pp_next),
        .ct_rd   (cp_next),
        .flag_we (flag_we),
        .flag_wa (flag_wa),
        .flag_wd (flag_wd),
        .x_we    (x_we),
        .x_wa    (pp_reg),
        .x_wd    (x_wd),
        .ce_we   (ce_we),
        .ce_wa   (cp_reg),
        .ce_wd   (ce_wd),
        .flag_q  (flag_q),
        .x_q     (x_q),
        .ce_q    (ce_q)
    );

    always_comb
    begin
        logic [15:0] v;
        logic        done;
        logic        lst;

        v    = {hb_reg, data_byte};
        done = 1'b0;
        lst  = 1'b0;

        phase_next  = phase_reg;
        seq_next    = seq_reg;
        fbc_next    = fbc_reg;
        hb_next     = hb_reg;
        ctot_next   = ctot_reg;
        cp_next     = cp_reg;
        ptot_next   = ptot_reg;
        pp_next     = pp_reg;
        ilen_next   = ilen_reg;
        rep_next    = rep_reg;
        xr_next     = xr_reg;
        yr_next     = yr_reg;
        ce_acc_next = ce_acc_reg;

        ovalid_next = ovalid_reg && out_stall;
        px_next     = px_reg;
        py_next     = py_reg;
        on_next     = on_reg;
        ce_next     = ce_reg;
        st_next     = st_reg;
        last_next   = last_reg;

        flag_we = 1'b0;
        flag_wa = pp_reg;
        flag_wd = flag_q;
        x_we    = 1'b0;
        x_wd    = xr_reg;
        ce_we   = 1'b0;
        ce_wd   = v;

        unique case (seq_reg)
            S_IN:
            begin
                if (accept && start_req)
                begin
                    phase_next = gopd_pkg::PH_HEAD;
                    fbc_next   = 4'd1;
                    hb_next    = data_byte;
                    ctot_next  = '0;
                    cp_next    = '0;
                    ptot_next  = '0;
                    pp_next    = '0;
                    ilen_next  = '0;
                    rep_next   = '0;
                    xr_next    = '0;
                    yr_next    = '0;
                end
                else if (accept)
                begin
                    unique case (phase_reg)
                        gopd_pkg::PH_HEAD:
                        begin
                            if (fbc_reg == 4'd0)
                            begin
                                hb_next  = data_byte;
                                fbc_next = 4'd1;
                            end
                            else if (fbc_reg == 4'd1 &&
                                     (v == 16'd0 || v[15] ||
                                      v > 16'(MAX_CONTOURS)))
                            begin
                                ovalid_next = 1'b1;
                                px_next     = '0;
                                py_next     = '0;
                                on_next     = 1'b0;
                                ce_next     = 1'b0;
                                last_next   = 1'b1;
                                phase_next  = gopd_pkg::PH_IDLE;
                                if (v == 16'd0)
                                    st_next = gopd_pkg::ST_NO_CONT;
                                else if (v[15])
                                    st_next = gopd_pkg::ST_COMPOUND;
                                else
                                    st_next = gopd_pkg::ST_CAPACITY;
                            end
                            else
                            begin
                                if (fbc_reg == 4'd1)
                                    ctot_next = v[CW-1:0];
                                fbc_next = fbc_reg + 4'd1;
                                if (fbc_reg == 4'(gopd_pkg::HEAD_BYTES - 1))
                                begin
                                    fbc_next   = 4'd0;
                                    cp_next    = '0;
                                    phase_next = gopd_pkg::PH_ENDS;
                                end
                            end
                        end
                        gopd_pkg::PH_ENDS:
                        begin
                            if (fbc_reg == 4'd0)
                            begin
                                hb_next  = data_byte;
                                fbc_next = 4'd1;
                            end
                            else
                            begin
                                fbc_next = 4'd0;
                                if (v >= 16'(MAX_POINTS) || cp_reg >= CW'(MAX_CONTOURS))
                                begin
                                    ovalid_next = 1'b1;
                                    px_next     = '0;
                                    py_next     = '0;
                                    on_next     = 1'b0;
                                    ce_next     = 1'b0;
                                    last_next   = 1'b1;
                                    st_next     = gopd_pkg::ST_CAPACITY;
                                    phase_next  = gopd_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    ce_we = 1'b1;
                                    if (v[PW-1:0] + PW'(1) > ptot_reg)
                                        ptot_next = v[PW-1:0] + PW'(1);
                                    cp_next = cp_reg + CW'(1);
                                    if (cp_reg + CW'(1) >= ctot_reg)
                                    begin
                                        cp_next    = '0;
                                        phase_next = gopd_pkg::PH_ILEN;
                                    end
                                end
                            end
                        end
                        gopd_pkg::PH_ILEN:
                        begin
                            if (fbc_reg == 4'd0)
                            begin
                                hb_next  = data_byte;
                                fbc_next = 4'd1;
                            end
                            else
                            begin
                                fbc_next   = 4'd0;
                                ilen_next  = v;
                                pp_next    = '0;
                                phase_next = (v != 16'd0) ? gopd_pkg::PH_INSTR :
                                                            gopd_pkg::PH_FLAGS;
                            end
                        end
                        gopd_pkg::PH_INSTR:
                        begin
                            ilen_next = ilen_reg - 16'd1;
                            if (ilen_reg == 16'd1)
                                phase_next = gopd_pkg::PH_FLAGS;
                        end
                        gopd_pkg::PH_FLAGS:
                        begin
                            if (fbc_reg == 4'd0)
                            begin
                                flag_we = (pp_reg < PW'(MAX_POINTS));
                                flag_wd = data_byte[5:0];
                                pp_next = pp_reg + PW'(1);
                                if (data_byte[3])
                                begin
                                    hb_next  = {2'b00, data_byte[5:0]};
                                    fbc_next = 4'd1;
                                end
                                else if (pp_reg + PW'(1) >= ptot_reg)
                                begin
                                    phase_next = gopd_pkg::PH_XS;
                                    pp_next    = '0;
                                    seq_next   = S_XSET;
                                end
                            end
                            else
                            begin
                                fbc_next = 4'd0;
                                rep_next = data_byte;
                                seq_next = S_REP;
                            end
                        end
                        gopd_pkg::PH_XS:
                        begin
                            if (pp_reg >= ptot_reg || pp_reg >= PW'(MAX_POINTS))
                            begin
                                seq_next = S_XSET;
                            end
                            else
                            begin
                                if (flag_q[1])
                                begin
                                    xr_next = flag_q[4] ? xr_reg + {8'd0, data_byte} :
                                                          xr_reg - {8'd0, data_byte};
                                    done    = 1'b1;
                                end
                                else if (fbc_reg == 4'd0)
                                begin
                                    hb_next  = data_byte;
                                    fbc_next = 4'd1;
                                end
                                else
                                begin
                                    fbc_next = 4'd0;
                                    xr_next  = xr_reg + v;
                                    done     = 1'b1;
                                end
                                if (done)
                                begin
                                    x_we     = 1'b1;
                                    x_wd     = xr_next;
                                    pp_next  = pp_reg + PW'(1);
                                    seq_next = S_XSET;
                                end
                            end
                        end
                        gopd_pkg::PH_YS:
                        begin
                            if (pp_reg >= ptot_reg || pp_reg >= PW'(MAX_POINTS))
                            begin
                                phase_next = gopd_pkg::PH_IDLE;
                            end
                            else
                            begin
                                if (flag_q[2])
                                begin
                                    yr_next = flag_q[5] ? yr_reg + {8'd0, data_byte} :
                                                          yr_reg - {8'd0, data_byte};
                                    done    = 1'b1;
                                end
                                else if (fbc_reg == 4'd0)
                                begin
                                    hb_next  = data_byte;
                                    fbc_next = 4'd1;
                                end
                                else
                                begin
                                    fbc_next = 4'd0;
                                    yr_next  = yr_reg + v;
                                    done     = 1'b1;
                                end
                                if (done)
                                begin
                                    ce_acc_next = 1'b0;
                                    seq_next    = S_WALK;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REP:
            begin
                if (rep_reg != 8'd0 && pp_reg < ptot_reg && pp_reg < PW'(MAX_POINTS))
                begin
                    flag_we  = 1'b1;
                    flag_wd  = hb_reg[5:0];
                    pp_next  = pp_reg + PW'(1);
                    rep_next = rep_reg - 8'd1;
                end
                else
                begin
                    rep_next = 8'd0;
                    if (pp_reg >= ptot_reg)
                    begin
                        phase_next = gopd_pkg::PH_XS;
                        pp_next    = '0;
                        seq_next   = S_XSET;
                    end
                    else
                    begin
                        seq_next = S_IN;
                    end
                end
            end
            S_XSET:
            begin
                if (pp_reg < ptot_reg && pp_reg < PW'(MAX_POINTS) &&
                    flag_q[4] && !flag_q[1])
                begin
                    x_we    = 1'b1;
                    x_wd    = xr_reg;
                    pp_next = pp_reg + PW'(1);
                end
                else if (pp_reg >= ptot_reg)
                begin
                    phase_next = gopd_pkg::PH_YS;
                    pp_next    = '0;
                    seq_next   = S_YSET;
                end
                else
                begin
                    seq_next = S_IN;
                end
            end
            S_YSET:
            begin
                if (phase_reg == gopd_pkg::PH_YS && pp_reg < ptot_reg &&
                    pp_reg < PW'(MAX_POINTS) && flag_q[5] && !flag_q[2])
                begin
                    ce_acc_next = 1'b0;
                    seq_next    = S_WALK;
                end
                else
                begin
                    seq_next = S_IN;
                end
            end
            S_WALK:
            begin
                if (cp_reg < ctot_reg && cp_reg < CW'(MAX_CONTOURS) &&
                    ce_q <= 16'(pp_reg))
                begin
                    ce_acc_next = ce_acc_reg || (ce_q == 16'(pp_reg));
                    cp_next     = cp_reg + CW'(1);
                end
                else if (out_free)
                begin
                    lst         = (pp_reg + PW'(1) >= ptot_reg);
                    ovalid_next = 1'b1;
                    px_next     = x_q;
                    py_next     = yr_reg;
                    on_next     = flag_q[0];
                    ce_next     = ce_acc_reg;
                    st_next     = gopd_pkg::ST_POINT;
                    last_next   = lst;
                    pp_next     = pp_reg + PW'(1);
                    if (lst)
                    begin
                        phase_next = gopd_pkg::PH_IDLE;
                        seq_next   = S_IN;
                    end
                    else
                    begin
                        seq_next = S_YSET;
                    end
                end
            end
            default:
            begin
                seq_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= gopd_pkg::PH_IDLE;
            seq_reg    <= S_IN;
            fbc_reg    <= '0;
            hb_reg     <= '0;
            ctot_reg   <= '0;
            cp_reg     <= '0;
            ptot_reg   <= '0;
            pp_reg     <= '0;
            ilen_reg   <= '0;
            rep_reg    <= '0;
            xr_reg     <= '0;
            yr_reg     <= '0;
            ce_acc_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            fbc_reg    <= fbc_next;
            hb_reg     <= hb_next;
            ctot_reg   <= ctot_next;
            cp_reg     <= cp_next;
            ptot_reg   <= ptot_next;
            pp_reg     <= pp_next;
            ilen_reg   <= ilen_next;
            rep_reg    <= rep_next;
            xr_reg     <= xr_next;
            yr_reg     <= yr_next;
            ce_acc_reg <= ce_acc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        on_reg   <= on_next;
        ce_reg   <= ce_next;
        st_reg   <= st_next;
        last_reg <= last_next;
    end

endmodule

// ===== tb/glyph_outline_point_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// testbench for glyph_outline_point_decoder_unit: byte records in, decoded points out
// depends on gopd_pkg and the decoder rtl; predicts each point from its own parser copy

module glyph_outline_point_decoder_unit_test;

    localparam int PT_CAP    = gopd_pkg::MAX_POINTS_DEF;
    localparam int CONT_CAP  = gopd_pkg::MAX_CONTOURS_DEF;
    localparam int WATCHDOG  = 4000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        on;
        logic        ce;
        logic [1:0]  st;
        logic        last;
    } point_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'd0;
    logic               start_req = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               on_curve;
    logic               contour_end;
    logic [1:0]         status;
    logic               last;

    glyph_outline_point_decoder_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .start_req(start_req),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y), .on_curve(on_curve),
        .contour_end(contour_end), .status(status), .last(last)
    );

    always #2 clk = ~clk;

    // parser copy
    logic [2:0]  parse_phase;
    int          field_count;
    logic [7:0]  byte_hold;
    int          n_contours;
    int          contour_idx;
    logic [15:0] contour_ends [CONT_CAP];
    int          n_points;
    int          point_idx;
    int          instr_left;
    logic [5:0]  point_flags [PT_CAP];
    logic [15:0] point_xs [PT_CAP];
    logic [15:0] x_acc;
    logic [15:0] y_acc;

    point_beat_t expected_points [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          idle_cycles = 0;
    bit          send_quiet = 0;
    bit          recv_quiet = 0;
    bit          hold_req = 0;
    logic [7:0]  glyph_bytes [$];

    function automatic void add_byte(input logic [7:0] b);
        glyph_bytes.insert(glyph_bytes.size(), b);
    endfunction

    function automatic void post_status(input logic [1:0] st);
        point_beat_t pb;
        pb = '{16'd0, 16'd0, 1'b0, 1'b0, st, 1'b1};
        expected_points.insert(expected_points.size(), pb);
        parse_phase = gopd_pkg::PH_IDLE;
    endfunction

    function automatic void post_point();
        int i;
        logic ce;
        logic lst;
        point_beat_t pb;
        i = point_idx;
        ce = 1'b0;
        if (i >= PT_CAP) begin
            parse_phase = gopd_pkg::PH_IDLE;
            return;
        end
        while (contour_idx < n_contours && contour_idx < CONT_CAP &&
               contour_ends[contour_idx] <= i) begin
            if (contour_ends[contour_idx] == i) ce = 1'b1;
            contour_idx++;
        end
        lst = (i + 1 >= n_points);
        pb = '{point_xs[i], y_acc, point_flags[i][0], ce, gopd_pkg::ST_POINT, lst};
        expected_points.insert(expected_points.size(), pb);
        point_idx++;
        if (lst) parse_phase = gopd_pkg::PH_IDLE;
    endfunction

    // byte-less coordinates
    function automatic void resolve_empty();
        if (parse_phase == gopd_pkg::PH_XS) begin
            while (point_idx < n_points && point_idx < PT_CAP &&
                   (point_flags[point_idx] & 6'h12) == 6'h10) begin
                point_xs[point_idx] = x_acc;
                point_idx++;
            end
            if (point_idx >= n_points) begin
                parse_phase = gopd_pkg::PH_YS;
                point_idx = 0;
            end
        end
        while (parse_phase == gopd_pkg::PH_YS && point_idx < n_points &&
               point_idx < PT_CAP && (point_flags[point_idx] & 6'h24) == 6'h20)
            post_point();
    endfunction

    function automatic void flags_done_check();
        if (point_idx >= n_points) begin
            parse_phase = gopd_pkg::PH_XS;
            point_idx = 0;
            resolve_empty();
        end
    endfunction

    function automatic bit add_delta(input logic [7:0] b, input logic [5:0] f,
                                     input int short_bit, input int pos_bit,
                                     inout logic [15:0] acc);
        if (f[short_bit]) begin
            acc = f[pos_bit] ? acc + {8'd0, b} : acc - {8'd0, b};
            return 1;
        end
        if (field_count == 0) begin
            byte_hold = b;
            field_count = 1;
            return 0;
        end
        field_count = 0;
        acc = acc + {byte_hold, b};
        return 1;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic s);
        logic [15:0] v;
        logic [5:0]  f;
        int          rep;
        if (s) begin
            parse_phase = gopd_pkg::PH_HEAD;
            field_count = 0;
            n_contours = 0;
            contour_idx = 0;
            n_points = 0;
            point_idx = 0;
            instr_left = 0;
            x_acc = '0;
            y_acc = '0;
        end
        case (parse_phase)
            gopd_pkg::PH_HEAD: begin
                if (field_count == 1) begin
                    v = {byte_hold, b};
                    if (v == 0) begin
                        post_status(gopd_pkg::ST_NO_CONT);
                        return;
                    end
                    if (v[15]) begin
                        post_status(gopd_pkg::ST_COMPOUND);
                        return;
                    end
                    if (v > CONT_CAP) begin
                        post_status(gopd_pkg::ST_CAPACITY);
                        return;
                    end
                    n_contours = int'(v);
                end else if (field_count == 0) begin
                    byte_hold = b;
                end
                field_count++;
                if (field_count >= gopd_pkg::HEAD_BYTES) begin
                    field_count = 0;
                    contour_idx = 0;
                    parse_phase = gopd_pkg::PH_ENDS;
                end
            end
            gopd_pkg::PH_ENDS: begin
                if (field_count == 0) begin
                    byte_hold = b;
                    field_count = 1;
                end else begin
                    field_count = 0;
                    v = {byte_hold, b};
                    if (v >= PT_CAP || contour_idx >= CONT_CAP) begin
                        post_status(gopd_pkg::ST_CAPACITY);
                    end else begin
                        contour_ends[contour_idx] = v;
                        if (int'(v) + 1 > n_points) n_points = int'(v) + 1;
                        contour_idx++;
                        if (contour_idx >= n_contours) begin
                            contour_idx = 0;
                            parse_phase = gopd_pkg::PH_ILEN;
                        end
                    end
                end
            end
            gopd_pkg::PH_ILEN: begin
                if (field_count == 0) begin
                    byte_hold = b;
                    field_count = 1;
                end else begin
                    field_count = 0;
                    instr_left = int'({byte_hold, b});
                    point_idx = 0;
                    parse_phase = (instr_left != 0) ? gopd_pkg::PH_INSTR :
                                                      gopd_pkg::PH_FLAGS;
                end
            end
            gopd_pkg::PH_INSTR: begin
                instr_left--;
                if (instr_left == 0) parse_phase = gopd_pkg::PH_FLAGS;
            end
            gopd_pkg::PH_FLAGS: begin
                if (field_count == 0) begin
                    f = b[5:0];
                    if (point_idx < PT_CAP) point_flags[point_idx] = f;
                    point_idx++;
                    if (f[3]) begin
                        byte_hold = {2'b00, f};
                        field_count = 1;
                        return;
                    end
                end else begin
                    field_count = 0;
                    rep = int'(b);
                    while (rep > 0 && point_idx < n_points && point_idx < PT_CAP) begin
                        point_flags[point_idx] = byte_hold[5:0];
                        point_idx++;
                        rep--;
                    end
                end
                flags_done_check();
            end
            gopd_pkg::PH_XS: begin
                if (point_idx >= n_points || point_idx >= PT_CAP) begin
                    resolve_empty();
                end else if (add_delta(b, point_flags[point_idx], 1, 4, x_acc)) begin
                    point_xs[point_idx] = x_acc;
                    point_idx++;
                    resolve_empty();
                end
            end
            gopd_pkg::PH_YS: begin
                if (point_idx >= n_points || point_idx >= PT_CAP) begin
                    parse_phase = gopd_pkg::PH_IDLE;
                end else if (add_delta(b, point_flags[point_idx], 2, 5, y_acc)) begin
                    post_point();
                    resolve_empty();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        in_valid <= 1'b1;
        data_byte <= b;
        start_req <= s;
        do @(posedge clk); while (in_stall);
        predict_byte(b, s);
        bytes_sent++;
        gap = send_quiet ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            start_req <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_points.size() > 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // build a well-formed record into glyph_bytes
    task automatic make_glyph(input int ncont, input int npts, input int ilen,
                              input bit scrambled);
        logic [15:0] ends [$];
        logic [5:0]  expanded [$];
        logic [7:0]  fb;
        int          p;
        int          r;
        int          k;
        glyph_bytes.delete();
        add_byte(ncont[15:8]);
        add_byte(ncont[7:0]);
        repeat (8) add_byte(8'($urandom));
        for (k = 0; k < ncont; k++)
            ends.insert(ends.size(), 16'($urandom_range(0, npts - 1)));
        if (!scrambled) begin
            ends[ncont - 1] = 16'(npts - 1);
            ends.sort();
        end else begin
            ends[$urandom_range(0, ncont - 1)] = 16'(npts - 1);
        end
        foreach (ends[j]) begin
            add_byte(ends[j][15:8]);
            add_byte(ends[j][7:0]);
        end
        add_byte(ilen[15:8]);
        add_byte(ilen[7:0]);
        repeat (ilen) add_byte(8'($urandom));
        p = 0;
        while (p < npts) begin
            fb = 8'($urandom);
            add_byte(fb);
            expanded.insert(expanded.size(), fb[5:0]);
            p++;
            if (fb[3]) begin
                r = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 255);
                add_byte(r[7:0]);
                k = (r < npts - p) ? r : npts - p;
                repeat (k) expanded.insert(expanded.size(), fb[5:0]);
                p += k;
            end
        end
        foreach (expanded[j]) begin
            if (expanded[j][1]) add_byte(8'($urandom));
            else if (!expanded[j][4]) repeat (2) add_byte(8'($urandom));
        end
        foreach (expanded[j]) begin
            if (expanded[j][2]) add_byte(8'($urandom));
            else if (!expanded[j][5]) repeat (2) add_byte(8'($urandom));
        end
    endtask

    task automatic send_glyph_bytes(input int count);
        for (int j = 0; j < count && j < glyph_bytes.size(); j++)
            send_byte(glyph_bytes[j], j == 0);
    endtask

    task automatic send_header(input logic [15:0] nc);
        send_byte(nc[15:8], 1'b1);
        send_byte(nc[7:0], 1'b0);
    endtask

    task automatic test_header_status();
        send_header(16'h0000);
        send_header(16'h8000);
        send_header(16'hFFFF);
        send_header(16'(CONT_CAP + 1));
        send_header(16'h7FFF);
        // end index beyond point capacity
        make_glyph(1, 1, 0, 0);
        glyph_bytes[10] = 8'h00;
        glyph_bytes[11] = 8'(PT_CAP);
        send_glyph_bytes(12);
        glyph_bytes[10] = 8'hFF;
        glyph_bytes[11] = 8'hFF;
        send_glyph_bytes(12);
    endtask

    task automatic test_idle_and_restart();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        make_glyph(2, 3, 2, 0);
        send_glyph_bytes(glyph_bytes.size() - 1);
        make_glyph(1, 1, 0, 0);
        send_glyph_bytes(glyph_bytes.size());
    endtask

    task automatic test_long_receiver_hold();
        hold_req = 1;
        make_glyph(3, 20, 1, 0);
        send_glyph_bytes(glyph_bytes.size());
        wait_drained();
    endtask

    task automatic test_random_glyphs(input int budget);
        int stop_at;
        int r;
        int np;
        int nc;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            send_quiet = ($urandom_range(0, 9) == 0);
            recv_quiet = send_quiet;
            np = ($urandom_range(0, 19) == 0) ? $urandom_range(13, PT_CAP)
                                               : $urandom_range(1, 12);
            nc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CONT_CAP)
                                              : $urandom_range(1, 4);
            if (r < 75) begin
                make_glyph(nc, np, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0,
                           $urandom_range(0, 4) == 0);
                send_glyph_bytes(glyph_bytes.size());
            end else if (r < 85) begin
                make_glyph(nc, np, $urandom_range(0, 2), 0);
                send_glyph_bytes($urandom_range(1, glyph_bytes.size()));
            end else if (r < 92) begin
                send_header(16'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 4) == 0);
            end
        end
        send_quiet = 0;
        recv_quiet = 0;
    endtask

    // result side stall pattern
    int stall_run = 0;
    bit stall_level = 0;
    always @(negedge clk) begin
        if (stall_run == 0) begin
            if (hold_req) begin
                stall_level = 1;
                stall_run = LONG_HOLD;
                hold_req = 0;
            end else if (recv_quiet) begin
                stall_level = 0;
                stall_run = 1;
            end else begin
                stall_level = ($urandom_range(0, 2) == 0);
                stall_run = pick_gap() + 1;
            end
        end
        out_stall <= stall_level;
        stall_run--;
    end

    always @(posedge clk) begin
        point_beat_t exp_pt;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%0d y=%0d st=%0d",
                             point_x, point_y, status);
            end else begin
                exp_pt = expected_points.pop_front();
                if (point_x !== exp_pt.x || point_y !== exp_pt.y ||
                    on_curve !== exp_pt.on || contour_end !== exp_pt.ce ||
                    status !== exp_pt.st || last !== exp_pt.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%0d y=%0d on=%0d ce=%0d st=%0d last=%0d %s",
                                 $signed(exp_pt.x), $signed(exp_pt.y), exp_pt.on,
                                 exp_pt.ce, exp_pt.st, exp_pt.last, "");
                    if (mismatches <= 10)
                        $display("         got x=%0d y=%0d on=%0d ce=%0d st=%0d last=%0d",
                                 point_x, point_y, on_curve, contour_end, status, last);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        parse_phase = gopd_pkg::PH_IDLE;
        field_count = 0;
        byte_hold = '0;
        n_contours = 0;
        contour_idx = 0;
        n_points = 0;
        point_idx = 0;
        instr_left = 0;
        x_acc = '0;
        y_acc = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_header_status();
        test_idle_and_restart();
        test_random_glyphs(75);
        test_long_receiver_hold();
        test_random_glyphs(75);
        in_valid <= 1'b0;
        while (expected_points.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
